/* rtl/local_mean_binarizer_assert.svh */
// ----------------------------------------------------------------------------
// Local mean binarizer assertion macros
// Concurrent checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LOCAL_MEAN_BINARIZER_ASSERT_SVH
`define LOCAL_MEAN_BINARIZER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LMB_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("local_mean_binarizer: check failed");
`define LMB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("local_mean_binarizer: check failed");
`else
`define LMB_ASSERT_NEVER(lbl, expr)
`define LMB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/lmb_pkg.sv */
// ----------------------------------------------------------------------------
// lmb_pkg
// Shared constants, register indexes, state and memory control types.
// ----------------------------------------------------------------------------
package lmb_pkg;

	localparam int LMB_MAX_WIDTH  = 1024;
	localparam int LMB_MAX_HEIGHT = 1024;
	localparam int LMB_MAX_HALF   = 7;

	localparam int LMB_IDX_W      = 3;
	localparam int LMB_CFG_DATA_W = 11;
	localparam int LMB_PIX_W      = 8;

	localparam logic [LMB_IDX_W-1:0] REG_THRESHOLD    = 3'd0;
	localparam logic [LMB_IDX_W-1:0] REG_HALF_WINDOW  = 3'd1;
	localparam logic [LMB_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
	localparam logic [LMB_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd3;

	localparam logic [7:0]  THRESHOLD_RST    = 8'd128;
	localparam logic [2:0]  HALF_WINDOW_RST  = 3'd1;
	localparam logic [10:0] IMAGE_WIDTH_RST  = 11'd640;
	localparam logic [10:0] IMAGE_HEIGHT_RST = 11'd480;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_DECIDE
	} lmb_state_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} lmb_mem_ctl_t;

endpackage

/* rtl/lmb_channels.sv */
// ----------------------------------------------------------------------------
// lmb channels
// Valid/ready channel interfaces for pixels, results and register writes.
// ----------------------------------------------------------------------------
interface lmb_pix_if import lmb_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 opcode;
	logic [LMB_PIX_W-1:0] pixel;
	modport source (output valid, opcode, pixel, input ready);
	modport sink (input valid, opcode, pixel, output ready);
endinterface

interface lmb_res_if;
	logic valid;
	logic ready;
	logic white;
	logic frame_end;
	modport source (output valid, white, frame_end, input ready);
	modport sink (input valid, white, frame_end, output ready);
endinterface

interface lmb_cfg_if import lmb_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [LMB_IDX_W-1:0]      index;
	logic [LMB_CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/lmb_row_store.sv */
// ----------------------------------------------------------------------------
// lmb_row_store
// Ring of row buffers, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lmb_row_store import lmb_pkg::*; #(
	parameter int RING_ROWS = 2 * LMB_MAX_HALF + 1,
	parameter int MAX_WIDTH = LMB_MAX_WIDTH
) (
	input  logic                         clk,
	input  lmb_mem_ctl_t                 ctl,
	input  logic [$clog2(RING_ROWS)-1:0] wr_ring,
	input  logic [$clog2(MAX_WIDTH)-1:0] wr_col,
	input  logic [LMB_PIX_W-1:0]         wr_data,
	input  logic [$clog2(RING_ROWS)-1:0] rd_ring,
	input  logic [$clog2(MAX_WIDTH)-1:0] rd_col,
	output logic [LMB_PIX_W-1:0]         rd_data
);

	logic [LMB_PIX_W-1:0] mem [RING_ROWS][MAX_WIDTH];
	logic [LMB_PIX_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_ring][wr_col] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_ring][rd_col];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/lmb_core.sv */
// ----------------------------------------------------------------------------
// lmb_core
// Raster counters, window scan over the row store, threshold decision.
// ----------------------------------------------------------------------------
module lmb_core import lmb_pkg::*; #(
	parameter int MAX_WIDTH  = LMB_MAX_WIDTH,
	parameter int MAX_HEIGHT = LMB_MAX_HEIGHT,
	parameter int MAX_HALF   = LMB_MAX_HALF
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             clear,
	input  logic                                             in_fire,
	output logic                                             idle,
	input  logic                                             opcode,
	input  logic [LMB_PIX_W-1:0]                             pixel,
	output logic                                             res_valid,
	input  logic                                             res_ready,
	output logic                                             white,
	output logic                                             frame_end,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]                   w,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0]                  h,
	input  logic [$clog2(MAX_HALF+1)-1:0]                    r,
	input  logic [$clog2(MAX_HALF*(MAX_WIDTH+1)+1)-1:0]      delay,
	input  logic [7:0]                                       threshold,
	output lmb_mem_ctl_t                                     mem_ctl,
	output logic [$clog2(2*MAX_HALF+1)-1:0]                  wr_ring,
	output logic [$clog2(MAX_WIDTH)-1:0]                     wr_col,
	output logic [LMB_PIX_W-1:0]                             wr_data,
	output logic [$clog2(2*MAX_HALF+1)-1:0]                  rd_ring,
	output logic [$clog2(MAX_WIDTH)-1:0]                     rd_col,
	input  logic [LMB_PIX_W-1:0]                             rd_data
);

	localparam int RING = 2 * MAX_HALF + 1;
	localparam int RGW  = $clog2(RING);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int HW   = $clog2(MAX_HEIGHT + 1);
	localparam int RW   = $clog2(MAX_HALF + 1);
	localparam int DW   = $clog2(MAX_HALF * (MAX_WIDTH + 1) + 1);
	localparam int SW   = $clog2(RING * RING * 255 + 1);
	localparam int NW   = $clog2(RING * RING + 1);
	localparam int PW   = 9 + NW;

	function automatic logic [RGW-1:0] ring_inc(input logic [RGW-1:0] x);
		return (x == RGW'(RING - 1)) ? '0 : x + RGW'(1);
	endfunction

	lmb_state_t state_q, state_d;

	logic [CW-1:0]  in_col_q, out_col_q;
	logic [HW-1:0]  in_row_q, out_row_q;
	logic [RGW-1:0] in_ring_q, out_ring_q;
	logic [DW-1:0]  delay_cnt_q;

	logic [RGW-1:0] cur_ring_q, rows_left_q;
	logic [CW-1:0]  cur_col_q, x0_q, x1_q;
	logic           rd_pend_q;
	logic [SW-1:0]  sum_q;
	logic [NW-1:0]  cnt_q;
	logic           last_q;
	logic           out_valid_q, white_q, frame_end_q;

	logic           done, take, store, due, last, in_col_end, scan_end, issue, load;
	logic [CW-1:0]  w_m1;
	logic [HW-1:0]  rows_below;
	logic [RW-1:0]  dy_lo, dy_hi;
	logic [RGW-1:0] ring_start, rows_span;
	logic [CW-1:0]  x0, x1, cols_right;
	logic [PW-1:0]  prod;
	logic           white_c;

	// Item classification, window bounds for the next result, threshold test
	always_comb begin
		done       = in_row_q >= h;
		take       = in_fire && (done || opcode != OP_DRAIN);
		store      = in_fire && !done && opcode == OP_PIXEL;
		due        = take && delay_cnt_q >= delay;
		w_m1       = CW'(w - WW'(1));
		in_col_end = in_col_q == w_m1;
		last       = (32'(out_row_q) + 1 >= 32'(h)) && (out_col_q == w_m1);

		dy_lo      = (32'(out_row_q) >= 32'(r)) ? r : RW'(out_row_q);
		rows_below = h - HW'(1) - out_row_q;
		dy_hi      = (32'(rows_below) >= 32'(r)) ? r : RW'(rows_below);
		ring_start = (out_ring_q >= RGW'(dy_lo)) ? out_ring_q - RGW'(dy_lo)
			: out_ring_q + RGW'(RING) - RGW'(dy_lo);
		rows_span  = RGW'(dy_lo) + RGW'(dy_hi);
		x0         = (32'(out_col_q) >= 32'(r)) ? out_col_q - CW'(r) : '0;
		cols_right = w_m1 - out_col_q;
		x1         = (32'(cols_right) >= 32'(r)) ? out_col_q + CW'(r) : w_m1;

		scan_end   = cur_col_q == x1_q && rows_left_q == '0;
		// mean > threshold  <=>  sum >= (threshold + 1) * count
		prod       = PW'({1'b0, threshold} + 9'd1) * PW'(cnt_q);
		white_c    = 32'(sum_q) >= 32'(prod);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (due) state_d = ST_SCAN;
			ST_SCAN:   if (scan_end) state_d = ST_FLUSH;
			ST_FLUSH:  state_d = ST_DECIDE;
			ST_DECIDE: if (load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		idle  = state_q == ST_IDLE;
		issue = state_q == ST_SCAN;
		load  = state_q == ST_DECIDE && (!out_valid_q || res_ready);
		mem_ctl.wr_en = store;
		mem_ctl.rd_en = issue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_col_q    <= '0;
			in_row_q    <= '0;
			in_ring_q   <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			out_ring_q  <= '0;
			delay_cnt_q <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_pend_q <= issue;
			if (clear) begin
				in_col_q    <= '0;
				in_row_q    <= '0;
				in_ring_q   <= '0;
				out_col_q   <= '0;
				out_row_q   <= '0;
				out_ring_q  <= '0;
				delay_cnt_q <= '0;
			end else if (take) begin
				// the frame-done branch below resets the input side itself
				if (store && !(due && last)) begin
					if (in_col_end) begin
						in_col_q  <= '0;
						in_row_q  <= in_row_q + HW'(1);
						in_ring_q <= ring_inc(in_ring_q);
					end else begin
						in_col_q <= in_col_q + CW'(1);
					end
				end
				if (!due) begin
					delay_cnt_q <= delay_cnt_q + DW'(1);
				end else if (last) begin
					// frame done: back to the start, drop the input side too
					in_col_q    <= '0;
					in_row_q    <= '0;
					in_ring_q   <= '0;
					out_col_q   <= '0;
					out_row_q   <= '0;
					out_ring_q  <= '0;
					delay_cnt_q <= '0;
				end else if (out_col_q == w_m1) begin
					out_col_q  <= '0;
					out_row_q  <= out_row_q + HW'(1);
					out_ring_q <= ring_inc(out_ring_q);
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Scan datapath: address walk, accumulation and the result registers
	always_ff @(posedge clk) begin
		if (due && idle) begin
			cur_ring_q  <= ring_start;
			cur_col_q   <= x0;
			x0_q        <= x0;
			x1_q        <= x1;
			rows_left_q <= rows_span;
			last_q      <= last;
			sum_q       <= '0;
			cnt_q       <= '0;
		end else begin
			if (issue) begin
				if (cur_col_q == x1_q) begin
					cur_col_q <= x0_q;
					if (rows_left_q != '0) begin
						rows_left_q <= rows_left_q - RGW'(1);
						cur_ring_q  <= ring_inc(cur_ring_q);
					end
				end else begin
					cur_col_q <= cur_col_q + CW'(1);
				end
			end
			if (rd_pend_q) begin
				sum_q <= sum_q + SW'(rd_data);
				cnt_q <= cnt_q + NW'(1);
			end
		end
		if (load) begin
			white_q     <= white_c;
			frame_end_q <= last_q;
		end
	end

	assign wr_ring   = in_ring_q;
	assign wr_col    = in_col_q;
	assign wr_data   = pixel;
	assign rd_ring   = cur_ring_q;
	assign rd_col    = cur_col_q;
	assign res_valid = out_valid_q;
	assign white     = white_q;
	assign frame_end = frame_end_q;

endmodule

/* rtl/local_mean_binarizer.sv */
// ----------------------------------------------------------------------------
// local_mean_binarizer
// Flow: an item with a result holds off input until its window scan, one
//   row store read per window pixel, is through and the result is loaded;
//   an item with no result leaves the core idle. The window scan on the
//   single read port of the row store sets the rate for the others.
// Reset: registers to defaults, counters cleared, row store not cleared;
//   input is held off after reset and after each write until settle_q is 0.
// ----------------------------------------------------------------------------
`include "local_mean_binarizer_assert.svh"

module local_mean_binarizer import lmb_pkg::*; #(
	parameter int MAX_WIDTH  = LMB_MAX_WIDTH,
	parameter int MAX_HEIGHT = LMB_MAX_HEIGHT,
	parameter int MAX_HALF   = LMB_MAX_HALF
) (
	input logic         clk,
	input logic         arst_n,
	lmb_cfg_if.sink     cfg,
	lmb_pix_if.sink     pix,
	lmb_res_if.source   res
);

	localparam int RING = 2 * MAX_HALF + 1;
	localparam int RGW  = $clog2(RING);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int HW   = $clog2(MAX_HEIGHT + 1);
	localparam int RW   = $clog2(MAX_HALF + 1);
	localparam int DW   = $clog2(MAX_HALF * (MAX_WIDTH + 1) + 1);

	logic [7:0]  threshold_q;
	logic [2:0]  half_window_q;
	logic [10:0] image_width_q, image_height_q;
	logic [1:0]  settle_q;
	logic        cfg_fire, in_fire, core_idle;

	logic [WW-1:0]    w_c, w_q, w_m1h;
	logic [HW-1:0]    h_c, h_q, h_m1h;
	logic [RW-1:0]    r_c, r_q;
	logic [RW+WW-1:0] rw_prod;
	logic [DW-1:0]    delay_q;

	lmb_mem_ctl_t         mem_ctl;
	logic [RGW-1:0]       wr_ring, rd_ring;
	logic [CW-1:0]        wr_col, rd_col;
	logic [LMB_PIX_W-1:0] wr_data, rd_data;

	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q    <= THRESHOLD_RST;
			half_window_q  <= HALF_WINDOW_RST;
			image_width_q  <= IMAGE_WIDTH_RST;
			image_height_q <= IMAGE_HEIGHT_RST;
			settle_q       <= 2'd2;
		end else begin
			if (cfg_fire) begin
				settle_q <= 2'd2;
				unique case (cfg.index)
					REG_THRESHOLD:    threshold_q    <= cfg.data[7:0];
					REG_HALF_WINDOW:  half_window_q  <= cfg.data[2:0];
					REG_IMAGE_WIDTH:  image_width_q  <= cfg.data;
					REG_IMAGE_HEIGHT: image_height_q <= cfg.data;
					default: ;
				endcase
			end else if (settle_q != 2'd0) begin
				settle_q <= settle_q - 2'd1;
			end
		end
	end

	// Clamp the frame size and the reach of the window
	always_comb begin
		if (image_width_q == '0) begin
			w_c = WW'(1);
		end else if (32'(image_width_q) > MAX_WIDTH) begin
			w_c = WW'(MAX_WIDTH);
		end else begin
			w_c = WW'(image_width_q);
		end
		if (image_height_q == '0) begin
			h_c = HW'(1);
		end else if (32'(image_height_q) > MAX_HEIGHT) begin
			h_c = HW'(MAX_HEIGHT);
		end else begin
			h_c = HW'(image_height_q);
		end
		w_m1h = (w_c - WW'(1)) >> 1;
		h_m1h = (h_c - HW'(1)) >> 1;
		r_c = (32'(half_window_q) > MAX_HALF) ? RW'(MAX_HALF) : RW'(half_window_q);
		if (32'(w_m1h) < 32'(r_c)) begin
			r_c = RW'(w_m1h);
		end
		if (32'(h_m1h) < 32'(r_c)) begin
			r_c = RW'(h_m1h);
		end
	end

	assign rw_prod = (RW+WW)'(r_q) * (RW+WW)'(w_q);

	always_ff @(posedge clk) begin
		w_q     <= w_c;
		h_q     <= h_c;
		r_q     <= r_c;
		delay_q <= DW'(rw_prod + (RW+WW)'(r_q));
	end

	assign pix.ready = core_idle && settle_q == 2'd0;
	assign in_fire   = pix.valid && pix.ready;

	lmb_core #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_HALF   (MAX_HALF)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (cfg_fire),
		.in_fire   (in_fire),
		.idle      (core_idle),
		.opcode    (pix.opcode),
		.pixel     (pix.pixel),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.white     (res.white),
		.frame_end (res.frame_end),
		.w         (w_q),
		.h         (h_q),
		.r         (r_q),
		.delay     (delay_q),
		.threshold (threshold_q),
		.mem_ctl   (mem_ctl),
		.wr_ring   (wr_ring),
		.wr_col    (wr_col),
		.wr_data   (wr_data),
		.rd_ring   (rd_ring),
		.rd_col    (rd_col),
		.rd_data   (rd_data)
	);

	lmb_row_store #(
		.RING_ROWS (RING),
		.MAX_WIDTH (MAX_WIDTH)
	) u_row_store (
		.clk     (clk),
		.ctl     (mem_ctl),
		.wr_ring (wr_ring),
		.wr_col  (wr_col),
		.wr_data (wr_data),
		.rd_ring (rd_ring),
		.rd_col  (rd_col),
		.rd_data (rd_data)
	);

	// a pixel is stored only while no window scan is reading
	`LMB_ASSERT_NEVER(a_no_rw_overlap, mem_ctl.wr_en && mem_ctl.rd_en)
	// the cycle after a scan read, input stays held off
	`LMB_ASSERT_NEXT(a_scan_blocks_input, mem_ctl.rd_en, !pix.ready)

endmodule

/* bench/local_mean_binarizer_test.sv */
// ----------------------------------------------------------------------------
// local_mean_binarizer_test
// Streams grayscale frames with drain ticks through the binarizer under random
// sender gaps and receiver stalls. A scoreboard keeps its own row ring and
// raster counters, works out each white/black mark and checks it on arrival.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module local_mean_binarizer_test;
	import lmb_pkg::*;

	localparam int RING_ROWS  = 2 * LMB_MAX_HALF + 1;
	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE     = 300;
	localparam int ITEM_GOAL  = 1250;

	typedef struct packed {
		logic white;
		logic frame_end;
	} mark_t;

	class binarize_board;
		bit [7:0]    ring [RING_ROWS*LMB_MAX_WIDTH];
		bit [7:0]    thr;
		bit [2:0]    half;
		bit [10:0]   img_w;
		bit [10:0]   img_h;
		int unsigned in_col, in_row, out_col, out_row, delay_cnt;
		mark_t       pending[$];
		int          errors;

		function new();
			thr    = THRESHOLD_RST;
			half   = HALF_WINDOW_RST;
			img_w  = IMAGE_WIDTH_RST;
			img_h  = IMAGE_HEIGHT_RST;
			errors = 0;
			clear();
		endfunction

		function void clear();
			in_col = 0; in_row = 0; out_col = 0; out_row = 0; delay_cnt = 0;
		endfunction

		function int unsigned cols();
			if (img_w < 1) return 1;
			if (img_w > LMB_MAX_WIDTH) return LMB_MAX_WIDTH;
			return img_w;
		endfunction

		function int unsigned rows();
			if (img_h < 1) return 1;
			if (img_h > LMB_MAX_HEIGHT) return LMB_MAX_HEIGHT;
			return img_h;
		endfunction

		function int unsigned reach();
			int unsigned r;
			r = half;
			if (r > LMB_MAX_HALF) r = LMB_MAX_HALF;
			if (r > (cols() - 1) / 2) r = (cols() - 1) / 2;
			if (r > (rows() - 1) / 2) r = (rows() - 1) / 2;
			return r;
		endfunction

		function int unsigned delay_len();
			return reach() * cols() + reach();
		endfunction

		function void write_reg(logic [LMB_IDX_W-1:0] idx, logic [LMB_CFG_DATA_W-1:0] d);
			case (idx)
				REG_THRESHOLD:    thr = d[7:0];
				REG_HALF_WINDOW:  half = d[2:0];
				REG_IMAGE_WIDTH:  img_w = d;
				REG_IMAGE_HEIGHT: img_h = d;
				default: return;
			endcase
			clear();
		endfunction

		function void take_item(logic op, logic [7:0] px);
			int unsigned w, h, r, y0, y1, x0, x1, sum, cnt;
			mark_t m;
			w = cols();
			h = rows();
			r = reach();
			if (in_row < h) begin
				if (op == OP_DRAIN) return;
				ring[(in_row % RING_ROWS) * LMB_MAX_WIDTH + in_col] = px;
				in_col++;
				if (in_col >= w) begin
					in_col = 0;
					in_row++;
				end
			end
			if (delay_cnt < r * w + r) begin
				delay_cnt++;
				return;
			end
			y0 = (out_row >= r) ? out_row - r : 0;
			y1 = (out_row + r > h - 1) ? h - 1 : out_row + r;
			x0 = (out_col >= r) ? out_col - r : 0;
			x1 = (out_col + r > w - 1) ? w - 1 : out_col + r;
			sum = 0;
			cnt = 0;
			for (int unsigned y = y0; y <= y1; y++)
				for (int unsigned x = x0; x <= x1; x++) begin
					sum += ring[(y % RING_ROWS) * LMB_MAX_WIDTH + x];
					cnt++;
				end
			m.white = (sum / cnt > thr);
			m.frame_end = (out_row >= h - 1) && (out_col >= w - 1);
			pending.push_back(m);
			if (m.frame_end) begin
				clear();
			end else begin
				out_col++;
				if (out_col >= w) begin
					out_col = 0;
					out_row++;
				end
			end
		endfunction

		function void check_mark(logic white, logic frame_end);
			mark_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result white=%0b frame_end=%0b", white, frame_end);
				return;
			end
			want = pending.pop_front();
			if (want.white !== white || want.frame_end !== frame_end) begin
				errors++;
				if (errors <= 10)
					$display("mismatch at %0t: expected white=%0b frame_end=%0b, got %0b %0b",
						$realtime, want.white, want.frame_end, white, frame_end);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	lmb_pix_if pix ();
	lmb_res_if res ();
	lmb_cfg_if cfg ();

	local_mean_binarizer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.pix    (pix),
		.res    (res)
	);

	binarize_board board = new();
	int  items_sent = 0;
	int  burst_left = 0;
	int  idle_cycles = 0;
	bit  hold_req = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// check results before noting inputs so a same-edge pair stays in order
	always @(posedge clk) begin
		if (arst_n) begin
			if (res.valid && res.ready)
				board.check_mark(res.white, res.frame_end);
			if (pix.valid && pix.ready)
				board.take_item(pix.opcode, pix.pixel);
			if ((res.valid && res.ready) || (pix.valid && pix.ready) || (cfg.valid && cfg.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("local_mean_binarizer_test: done, errors");
				$finish;
			end
		end
	end

	// receiver: changing stall patterns, one long hold-off on request
	initial begin
		int mode;
		res.ready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 0;
				res.ready <= 0;
				repeat (2000) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 2);
				for (int i = 0; i < 64 && !hold_req; i++) begin
					case (mode)
						0: res.ready <= 1;
						1: res.ready <= ($urandom_range(0, 9) < 7);
						default: res.ready <= (i % 4 != 3);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	task automatic send_item(logic op, logic [7:0] px);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				pix.valid <= 0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		pix.valid  <= 1;
		pix.opcode <= op;
		pix.pixel  <= px;
		@(posedge clk);
		while (!pix.ready) @(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	// hold until every mark is in and the scan has run out
	task automatic settle();
		pix.valid <= 0;
		burst_left = 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [LMB_IDX_W-1:0] idx, logic [LMB_CFG_DATA_W-1:0] d);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data  <= d;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		board.write_reg(idx, d);
		cfg.valid <= 0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] pick_pixel();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'(board.thr + $urandom_range(0, 3) - 1);
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// pixels of one frame (or the first npix of it), then for a whole frame the drain ticks
	task automatic send_frame(bit noisy, int npix);
		int unsigned dl;
		for (int i = 0; i < npix; i++) begin
			if (noisy && $urandom_range(0, 9) == 0)
				send_item(OP_DRAIN, 8'($urandom_range(0, 255)));
			send_item(OP_PIXEL, pick_pixel());
		end
		if (npix < board.cols() * board.rows()) return;
		dl = board.delay_len();
		for (int unsigned d = 0; d < dl; d++) begin
			if (noisy && $urandom_range(0, 3) == 0)
				send_item(OP_PIXEL, 8'($urandom_range(0, 255)));
			else
				send_item(OP_DRAIN, 8'($urandom_range(0, 255)));
		end
		if (noisy && $urandom_range(0, 3) == 0)
			send_item(OP_DRAIN, 8'($urandom_range(0, 255)));
	endtask

	task automatic configure(bit [7:0] t, bit [2:0] h, bit [10:0] w, bit [10:0] ht);
		logic [LMB_IDX_W-1:0] order [4];
		order = '{REG_THRESHOLD, REG_HALF_WINDOW, REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT};
		order.shuffle();
		foreach (order[i]) begin
			case (order[i])
				REG_THRESHOLD:   write_reg(order[i], {3'($urandom_range(0, 7)), t});
				REG_HALF_WINDOW: write_reg(order[i], {8'($urandom_range(0, 255)), h});
				REG_IMAGE_WIDTH: write_reg(order[i], w);
				default:         write_reg(order[i], ht);
			endcase
		end
		if ($urandom_range(0, 3) == 0)
			write_reg(LMB_IDX_W'($urandom_range(4, 7)),
				LMB_CFG_DATA_W'($urandom_range(0, 2047)));
	endtask

	initial begin
		int phase;
		int kind;
		bit [10:0] w, ht;
		arst_n    = 0;
		pix.valid = 0; pix.opcode = 0; pix.pixel = 0;
		cfg.valid = 0; cfg.index = 0; cfg.data = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: 3x3 with an ignored tick, extremes, late pixel as drain
		configure(8'd100, 3'd1, 11'd3, 11'd3);
		send_item(OP_DRAIN, 8'd255);
		send_item(OP_PIXEL, 8'd0);
		send_item(OP_PIXEL, 8'd255);
		send_item(OP_PIXEL, 8'd255);
		send_item(OP_PIXEL, 8'd0);
		send_item(OP_DRAIN, 8'd0);
		send_item(OP_PIXEL, 8'd101);
		send_item(OP_PIXEL, 8'd100);
		send_item(OP_PIXEL, 8'd255);
		send_item(OP_PIXEL, 8'd0);
		send_item(OP_PIXEL, 8'd170);
		send_item(OP_PIXEL, 8'd77);
		send_item(OP_DRAIN, 8'd0);
		send_item(OP_DRAIN, 8'd0);
		send_item(OP_DRAIN, 8'd0);
		send_item(OP_DRAIN, 8'd0);
		settle();
		// zero size clamps to 1x1, top threshold never passes
		configure(8'd255, 3'd7, 11'd0, 11'd0);
		send_item(OP_PIXEL, 8'd255);
		send_item(OP_DRAIN, 8'd0);
		send_item(OP_PIXEL, 8'd255);
		settle();
		configure(8'd0, 3'd0, 11'd2, 11'd1);
		send_item(OP_PIXEL, 8'd0);
		send_item(OP_PIXEL, 8'd1);
		settle();

		phase = 0;
		while (items_sent < ITEM_GOAL) begin
			// wide or tall frames only early on, so the item count stays near the goal
			kind = (items_sent < ITEM_GOAL / 4) ? $urandom_range(0, 19) : $urandom_range(3, 19);
			if (kind == 0) begin
				w = 11'd2047; ht = 11'd1;
			end else if (kind == 1) begin
				w = 11'd1; ht = 11'd2047;
			end else if (kind == 2) begin
				w = 11'd1024; ht = 11'($urandom_range(0, 1));
			end else begin
				w = 11'($urandom_range(1, 16)); ht = 11'($urandom_range(1, 16));
			end
			configure($urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
				: 8'($urandom_range(60, 200)), 3'($urandom_range(0, 7)), w, ht);
			if (phase == 0)
				hold_req = 1;
			if ($urandom_range(0, 7) == 0) begin
				// abandon a frame part way
				send_frame(1, $urandom_range(1, board.cols() * board.rows()));
			end else begin
				repeat ((board.cols() * board.rows() > 256) ? 1 : $urandom_range(1, 3))
					send_frame(1'($urandom_range(0, 1)), board.cols() * board.rows());
			end
			settle();
			phase++;
		end

		if (board.pending.size() != 0)
			board.errors++;
		if (board.errors == 0)
			$display("local_mean_binarizer_test: done, clean");
		else
			$display("local_mean_binarizer_test: done, errors");
		$finish;
	end

endmodule
